// ----- rtl/sipq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and constants
// Entry layout, result record, compare result and sequencer states for the
// sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int SCORE_W = 8;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = 2 * SCORE_W;
    localparam int ENTRY_W = KEY_W + TAG_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0] major;
        logic [SCORE_W-1:0] minor;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic               accepted;
        logic               rejected_full;
        logic               first_rejection;
        logic               entry_valid;
        logic [SCORE_W-1:0] out_major;
        logic [SCORE_W-1:0] out_minor;
        logic [TAG_W-1:0]   out_tag;
        logic               last;
    } result_t;

    typedef struct packed {
        logic ge;
        logic gt;
    } cmp_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_CMP,
        S_SCAN_CMP,
        S_PLACE,
        S_DUMP_LD,
        S_OUT
    } state_t;

    function automatic logic [KEY_W-1:0] key_of(input entry_t e);
        return {e.major, e.minor};
    endfunction

endpackage : sipq_pkg
`default_nettype wire

// ----- rtl/sipq_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_in_if: request channel
// Valid/ready channel carrying one queue request per transfer.
// ----------------------------------------------------------------------------
interface sipq_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  major_key;
    logic [7:0]  minor_key;
    logic [15:0] tag;

    modport source (output valid, output func, output major_key, output minor_key,
                    output tag, input ready);
    modport sink   (input valid, input func, input major_key, input minor_key,
                    input tag, output ready);
endinterface : sipq_in_if
`default_nettype wire

// ----- rtl/sipq_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_out_if: result channel
// Valid/ready channel carrying one queue result per transfer.
// ----------------------------------------------------------------------------
interface sipq_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        rejected_full;
    logic        first_rejection;
    logic        entry_valid;
    logic [7:0]  out_major;
    logic [7:0]  out_minor;
    logic [15:0] out_tag;
    logic        last;

    modport source (output valid, output accepted, output rejected_full,
                    output first_rejection, output entry_valid, output out_major,
                    output out_minor, output out_tag, output last, input ready);
    modport sink   (input valid, input accepted, input rejected_full,
                    input first_rejection, input entry_valid, input out_major,
                    input out_minor, input out_tag, input last, output ready);
endinterface : sipq_out_if
`default_nettype wire

// ----- rtl/sorted_insert_priority_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core: bounded sorted priority queue
// Entries kept in descending (major, minor) order in a small RAM; inserts
// shift the tail one slot per step under a sequencer with one comparator.
//
//   channel | dir | transfer carries
//   in_ch   | in  | func, major_key, minor_key, tag
//   out_ch  | out | accepted, rejected_full, first_rejection, entry_valid,
//           |     | out_major, out_minor, out_tag, last
//
// Insert: a head compare, one scan step per entry moved, one more scan step
// when it does not land at the head, then the place step; then the result
// sits in the output register. Reject or empty dump: straight to the output
// register. Dump: a load step per entry, then its output transfer; the RAM's
// registered read port sets the pace. in_ch.ready is high only when idle.
// Reset empties the queue and clears the sticky full flag; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core
    import sipq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    sipq_in_if.sink   in_ch,
    sipq_out_if.source out_ch
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t           state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] pos_reg,     pos_next;
    logic             full_reg,    full_next;
    logic             head_ge_reg, head_ge_next;
    entry_t           entry_reg,   entry_next;
    result_t          res_reg,     res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;
    cmp_res_t         cmp;

    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] pos_m2;
    logic [CNT_W-1:0] pos_p1;
    logic             in_xfer;
    logic             out_xfer;
    logic             move;

    assign pos_m1   = pos_reg - CNT_W'(1);
    assign pos_m2   = pos_reg - CNT_W'(2);
    assign pos_p1   = pos_reg + CNT_W'(1);
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;

    sipq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sipq_cmp u_cmp (
        .new_key (key_of(entry_reg)),
        .old_key (key_of(ram_rdata)),
        .res     (cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        head_ge_reg <= head_ge_next;
        entry_reg   <= entry_next;
        res_reg     <= res_next;
    end

    // move: entry at pos-1 steps back one slot
    assign move = head_ge_reg || ((pos_reg != CNT_W'(1)) && cmp.gt);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        full_next    = full_reg;
        head_ge_next = head_ge_reg;
        entry_next   = entry_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg[IDX_W-1:0];
        ram_wdata    = ram_rdata;
        ram_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    entry_next.major = in_ch.major_key;
                    entry_next.minor = in_ch.minor_key;
                    entry_next.tag   = in_ch.tag;
                    res_next         = '0;
                    res_next.last    = 1'b1;
                    pos_next         = count_reg;
                    if (in_ch.func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_next.rejected_full   = 1'b1;
                            res_next.first_rejection = !full_reg;
                            full_next                = 1'b1;
                            state_next               = S_OUT;
                        end
                        else
                        begin
                            state_next = S_HEAD_CMP;
                        end
                    end
                    else
                    begin
                        pos_next = '0;
                        if (count_reg == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DUMP_LD;
                        end
                    end
                end
            end

            S_HEAD_CMP:
            begin
                head_ge_next = (count_reg == '0) || cmp.ge;
                ram_raddr    = pos_m1[IDX_W-1:0];
                if (pos_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                ram_raddr = pos_m2[IDX_W-1:0];
                if (move)
                begin
                    ram_we   = 1'b1;
                    pos_next = pos_m1;
                    if (pos_m1 == '0)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                ram_we            = 1'b1;
                ram_wdata         = entry_reg;
                count_next        = count_reg + CNT_W'(1);
                res_next.accepted = 1'b1;
                state_next        = S_OUT;
            end

            S_DUMP_LD:
            begin
                res_next             = '0;
                res_next.entry_valid = 1'b1;
                res_next.out_major   = ram_rdata.major;
                res_next.out_minor   = ram_rdata.minor;
                res_next.out_tag     = ram_rdata.tag;
                res_next.last        = (pos_p1 == count_reg);
                pos_next             = pos_p1;
                state_next           = S_OUT;
            end

            S_OUT:
            begin
                ram_raddr = pos_reg[IDX_W-1:0];
                if (out_xfer)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DUMP_LD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ch.ready            = (state_reg == S_IDLE);
    assign out_ch.valid           = (state_reg == S_OUT);
    assign out_ch.accepted        = res_reg.accepted;
    assign out_ch.rejected_full   = res_reg.rejected_full;
    assign out_ch.first_rejection = res_reg.first_rejection;
    assign out_ch.entry_valid     = res_reg.entry_valid;
    assign out_ch.out_major       = res_reg.out_major;
    assign out_ch.out_minor       = res_reg.out_minor;
    assign out_ch.out_tag         = res_reg.out_tag;
    assign out_ch.last            = res_reg.last;

endmodule : sorted_insert_priority_queue_core
`default_nettype wire

// ----- rtl/sipq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : sipq_ram
`default_nettype wire

// ----- rtl/sipq_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_cmp: shared key comparator
// Compares the pending entry's key against a stored key.
// ----------------------------------------------------------------------------
module sipq_cmp
    import sipq_pkg::*;
(
    input  logic [KEY_W-1:0] new_key,
    input  logic [KEY_W-1:0] old_key,
    output cmp_res_t         res
);

    always_comb
    begin
        res.ge = (new_key >= old_key);
        res.gt = (new_key >  old_key);
    end

endmodule : sipq_cmp
`default_nettype wire

// ----- tb/tb_sorted_insert_priority_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_core: self-checking bench for the queue core
// Drives insert and dump requests with random gaps and result-side stalls,
// tracks the expected queue contents in a local model and compares every
// result transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_core;
    import sipq_pkg::*;

    localparam int CAPACITY    = 8;
    localparam int CLK_HALF    = 10;
    localparam int RANDOM_REQS = 320;
    localparam int SHOW_LIMIT  = 10;
    localparam int DRAIN_WAIT  = 20;
    localparam int RUN_CYCLES  = 2000000;

    typedef struct {
        logic               func;
        logic [SCORE_W-1:0] major;
        logic [SCORE_W-1:0] minor;
        logic [TAG_W-1:0]   tag;
        bit                 drain;
    } req_t;

    logic clk;
    logic rst_n;

    sipq_in_if  in_ch ();
    sipq_out_if out_ch ();

    sorted_insert_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    req_t        pending_reqs[$];
    result_t     expected_results[$];
    entry_t      queue_slots[CAPACITY];
    int unsigned queue_fill;
    bit          overflow_seen;
    int unsigned mismatches;
    bit          req_in_flight;
    bit          req_taken;
    int unsigned src_gap;
    int unsigned src_calm;
    int unsigned sink_stall;
    int unsigned sink_calm;
    req_t        next_req;

    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(logic func, logic [SCORE_W-1:0] major,
                                    logic [SCORE_W-1:0] minor, logic [TAG_W-1:0] tag,
                                    bit drain);
        req_t req;
        req.func  = func;
        req.major = major;
        req.minor = minor;
        req.tag   = tag;
        req.drain = drain;
        pending_reqs.push_back(req);
    endfunction

    // Insert: head tie goes first, other ties go behind the equal entries.
    function automatic void predict_queue_op(req_t req);
        result_t          res;
        entry_t           item;
        logic [KEY_W-1:0] key;
        int unsigned      pos;
        int unsigned      i;
        res = '0;
        if (req.func == FUNC_INSERT)
        begin
            res.last = 1'b1;
            if (queue_fill >= CAPACITY)
            begin
                res.rejected_full   = 1'b1;
                res.first_rejection = !overflow_seen;
                overflow_seen       = 1'b1;
            end
            else
            begin
                item = {req.major, req.minor, req.tag};
                key  = {req.major, req.minor};
                pos  = 0;
                if (queue_fill != 0 && key < {queue_slots[0].major, queue_slots[0].minor})
                begin
                    pos = 1;
                    while (pos < queue_fill &&
                           key <= {queue_slots[pos].major, queue_slots[pos].minor})
                        pos++;
                end
                for (i = queue_fill; i > pos; i--)
                    queue_slots[i] = queue_slots[i-1];
                queue_slots[pos] = item;
                queue_fill++;
                res.accepted = 1'b1;
            end
            expected_results.push_back(res);
        end
        else if (queue_fill == 0)
        begin
            res.last = 1'b1;
            expected_results.push_back(res);
        end
        else
        begin
            for (i = 0; i < queue_fill; i++)
            begin
                res             = '0;
                res.entry_valid = 1'b1;
                res.out_major   = queue_slots[i].major;
                res.out_minor   = queue_slots[i].minor;
                res.out_tag     = queue_slots[i].tag;
                res.last        = (i + 1 == queue_fill);
                expected_results.push_back(res);
            end
        end
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("acc=%0b rej=%0b first=%0b vld=%0b major=%02h minor=%02h tag=%04h last=%0b",
                         r.accepted, r.rejected_full, r.first_rejection, r.entry_valid,
                         r.out_major, r.out_minor, r.out_tag, r.last);
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        string   diff;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("unexpected result transfer: %s", fmt_result(got));
            return;
        end
        want = expected_results.pop_front();
        diff = "";
        if (got.accepted !== want.accepted)               diff = {diff, " accepted"};
        if (got.rejected_full !== want.rejected_full)     diff = {diff, " rejected_full"};
        if (got.first_rejection !== want.first_rejection) diff = {diff, " first_rejection"};
        if (got.entry_valid !== want.entry_valid)         diff = {diff, " entry_valid"};
        if (got.out_major !== want.out_major)             diff = {diff, " out_major"};
        if (got.out_minor !== want.out_minor)             diff = {diff, " out_minor"};
        if (got.out_tag !== want.out_tag)                 diff = {diff, " out_tag"};
        if (got.last !== want.last)                       diff = {diff, " last"};
        if (diff != "")
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("mismatch on%s\n  expected %s\n  actual   %s",
                         diff, fmt_result(want), fmt_result(got));
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(2 * CLK_HALF * RUN_CYCLES);
        $display("FAIL");
        $finish;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken     = 1'b0;
                req_in_flight = 1'b0;
            end
            if (!req_in_flight)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_results.size() != 0))
                begin
                    next_req = pending_reqs.pop_front();
                    in_ch.func      <= next_req.func;
                    in_ch.major_key <= next_req.major;
                    in_ch.minor_key <= next_req.minor;
                    in_ch.tag       <= next_req.tag;
                    in_ch.valid     <= 1'b1;
                    req_in_flight = 1'b1;
                    src_gap       = draw_gap(src_calm);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_stall > 0)
            begin
                sink_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                sink_stall = draw_gap(sink_calm);
            end
        end
    end

    // monitor: predict on request transfer, check on result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_queue_op('{in_ch.func, in_ch.major_key, in_ch.minor_key,
                                   in_ch.tag, 1'b0});
                req_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
                check_result({out_ch.accepted, out_ch.rejected_full, out_ch.first_rejection,
                              out_ch.entry_valid, out_ch.out_major, out_ch.out_minor,
                              out_ch.out_tag, out_ch.last});
        end
    end

    initial
    begin
        int unsigned n;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_INSERT;
        in_ch.major_key = '0;
        in_ch.minor_key = '0;
        in_ch.tag       = '0;
        out_ch.ready    = 1'b0;
        queue_fill      = 0;
        overflow_seen   = 1'b0;
        mismatches      = 0;
        req_in_flight   = 1'b0;
        req_taken       = 1'b0;
        src_gap         = 0;
        src_calm        = 0;
        sink_stall      = 0;
        sink_calm       = 0;

        // empty dump, extreme keys, ties at head / middle / tail, fill, overflow
        add_req(FUNC_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0);
        add_req(FUNC_INSERT, 8'h00, 8'h00, 16'h0000, 1'b0);
        add_req(FUNC_INSERT, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        add_req(FUNC_INSERT, 8'hFF, 8'hFF, 16'h0001, 1'b0);
        add_req(FUNC_INSERT, 8'h00, 8'h00, 16'h0002, 1'b0);
        add_req(FUNC_INSERT, 8'h80, 8'h07, 16'hAAAA, 1'b0);
        add_req(FUNC_INSERT, 8'h80, 8'h07, 16'h5555, 1'b0);
        add_req(FUNC_INSERT, 8'h80, 8'h08, 16'h0003, 1'b0);
        add_req(FUNC_DUMP,   8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        add_req(FUNC_INSERT, 8'h7F, 8'hFF, 16'h0004, 1'b1);
        add_req(FUNC_INSERT, 8'hC8, 8'h00, 16'h0005, 1'b0);
        add_req(FUNC_INSERT, 8'h01, 8'h01, 16'h0006, 1'b0);
        add_req(FUNC_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0);
        add_req(FUNC_INSERT, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);

        for (n = 0; n < RANDOM_REQS; n++)
            add_req(($urandom_range(0, 3) == 0) ? FUNC_DUMP : FUNC_INSERT,
                    SCORE_W'($urandom), SCORE_W'($urandom), TAG_W'($urandom),
                    (n % 50) == 49);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_in_flight)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule : tb_sorted_insert_priority_queue_core
`default_nettype wire
